// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the divider sources.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SURD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SURD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/surd_pkg.sv =====
package surd_pkg;

  // Fixed widths of the word fields.
  localparam int FIELD_W = 32;
  localparam int CMD_W   = 2;

  // Default operand width of the division core.
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUO_U = 2'd0,
    CMD_REM_U = 2'd1,
    CMD_QUO_S = 2'd2,
    CMD_REM_S = 2'd3
  } cmd_t;

  // Control that travels with each word down the pipeline.
  typedef struct packed {
    cmd_t cmd;
    logic a_neg;
    logic b_neg;
  } ctl_t;

endpackage

// ===== rtl/surd_cmd_if.sv =====
interface surd_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [surd_pkg::CMD_W-1:0]   command;
  logic [surd_pkg::FIELD_W-1:0] dividend;
  logic [surd_pkg::FIELD_W-1:0] divisor;

  modport source (output valid, output command, output dividend, output divisor,
                  input ready);
  modport sink (input valid, input command, input dividend, input divisor,
                output ready);
endinterface

// ===== rtl/surd_res_if.sv =====
interface surd_res_if;
  logic                         valid;
  logic                         ready;
  logic [surd_pkg::FIELD_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

// ===== rtl/surd_prep.sv =====
module surd_prep #(
  parameter int DATA_WIDTH = surd_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  surd_cmd_if.sink              req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output surd_pkg::ctl_t        out_ctl,
  output logic [DATA_WIDTH-1:0] out_den,
  output logic [DATA_WIDTH-1:0] out_nq
);
  import surd_pkg::*;

  cmd_t                  cmd;
  logic [DATA_WIDTH-1:0] a;
  logic [DATA_WIDTH-1:0] b;
  logic                  is_signed;
  logic                  a_neg;
  logic                  b_neg;
  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;

  // Signed commands divide magnitudes; the signs ride along for the fixup.
  always_comb begin
    cmd       = cmd_t'(req.command);
    a         = DATA_WIDTH'(req.dividend);
    b         = DATA_WIDTH'(req.divisor);
    is_signed = cmd inside {CMD_QUO_S, CMD_REM_S};
    a_neg     = is_signed && a[DATA_WIDTH-1];
    b_neg     = is_signed && b[DATA_WIDTH-1];
    mag_a     = a_neg ? ('0 - a) : a;
    mag_b     = b_neg ? ('0 - b) : b;
  end

  assign req.ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.ready) begin
      out_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      out_ctl.cmd   <= cmd;
      out_ctl.a_neg <= a_neg;
      out_ctl.b_neg <= b_neg;
      out_den       <= mag_b;
      out_nq        <= mag_a;
    end
  end

endmodule

// ===== rtl/surd_step.sv =====
`include "assert_macros.svh"

module surd_step #(
  parameter int DATA_WIDTH = surd_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  surd_pkg::ctl_t        in_ctl,
  input  logic [DATA_WIDTH-1:0] in_den,
  input  logic [DATA_WIDTH-1:0] in_part,
  input  logic [DATA_WIDTH-1:0] in_nq,
  output logic                  out_valid,
  input  logic                  out_ready,
  output surd_pkg::ctl_t        out_ctl,
  output logic [DATA_WIDTH-1:0] out_den,
  output logic [DATA_WIDTH-1:0] out_part,
  output logic [DATA_WIDTH-1:0] out_nq
);
  import surd_pkg::*;

  // The nq word holds the dividend bits still to come in its upper part and
  // the quotient bits found so far in its lower part.
  logic                  carry;
  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  take;
  logic [DATA_WIDTH-1:0] part_next;
  logic [DATA_WIDTH-1:0] nq_next;

  // A carry out of the partial remainder forces the subtract.
  always_comb begin
    carry     = in_part[DATA_WIDTH-1];
    shifted   = {in_part[DATA_WIDTH-2:0], in_nq[DATA_WIDTH-1]};
    diff      = {carry, shifted} - {1'b0, in_den};
    take      = carry || !diff[DATA_WIDTH];
    part_next = take ? diff[DATA_WIDTH-1:0] : shifted;
    nq_next   = {in_nq[DATA_WIDTH-2:0], take};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_ctl  <= in_ctl;
      out_den  <= in_den;
      out_part <= part_next;
      out_nq   <= nq_next;
    end
  end

  `SURD_ASSERT_IMP(a_part_below_den, clk, rst, out_valid && (out_den != '0), out_part < out_den, "partial remainder not below divisor")
  `SURD_ASSERT_NXT(a_stall_holds, clk, rst, out_valid && !out_ready, $stable(out_part) && $stable(out_nq) && $stable(out_den), "stalled stage changed its word")

endmodule

// ===== rtl/surd_fix.sv =====
module surd_fix #(
  parameter int DATA_WIDTH = surd_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  surd_pkg::ctl_t        in_ctl,
  input  logic [DATA_WIDTH-1:0] in_part,
  input  logic [DATA_WIDTH-1:0] in_nq,
  surd_res_if.source            rsp
);
  import surd_pkg::*;

  logic [DATA_WIDTH-1:0] res;

  // Quotient is negated when the signs differ; remainder follows the dividend.
  always_comb begin
    case (in_ctl.cmd)
      CMD_QUO_U: res = in_nq;
      CMD_REM_U: res = in_part;
      CMD_QUO_S: res = (in_ctl.a_neg != in_ctl.b_neg) ? ('0 - in_nq) : in_nq;
      CMD_REM_S: res = in_ctl.a_neg ? ('0 - in_part) : in_part;
      default:   res = in_nq;
    endcase
  end

  assign in_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (in_ready) begin
      rsp.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rsp.result <= FIELD_W'(res);
    end
  end

endmodule

// ===== rtl/signed_unsigned_restoring_divider.sv =====
// An accepted word passes the prep register, the step registers and the fix output register.
// Throughput: one word per cycle unless the output stalls; a new word may enter whenever req.ready is high.
// Every stage has its own valid bit, so bubbles are squeezed out on a stall.
// Reset (rst, synchronous, active high) clears all valid bits; data does not reset.
`include "assert_macros.svh"

module signed_unsigned_restoring_divider #(
  parameter int DATA_WIDTH = surd_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  surd_cmd_if.sink   req,
  surd_res_if.source rsp
);
  import surd_pkg::*;

  // Pipeline layout:
  //   prep   - takes the magnitudes of signed operands and registers them.
  //   step k - one restoring division step per stage, DATA_WIDTH stages.
  //   fix    - selects quotient or remainder, applies the signs, and holds
  //            the result word in the output register.
  // Division by zero needs no special path: every step then subtracts zero,
  // which leaves an all-ones quotient and the dividend as the remainder.
  // The ready of each stage only looks at its own valid bit and the ready of
  // the stage after it, so a word enters whenever any stage has room.

  logic                  valid [DATA_WIDTH+1];
  logic                  ready [DATA_WIDTH+1];
  ctl_t                  ctl   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] den   [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] part  [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0] nq    [DATA_WIDTH+1];

  surd_prep #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_ctl   (ctl[0]),
    .out_den   (den[0]),
    .out_nq    (nq[0])
  );

  // The partial remainder starts at zero ahead of the first step.
  assign part[0] = '0;

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
    surd_step #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[k]),
      .in_ready  (ready[k]),
      .in_ctl    (ctl[k]),
      .in_den    (den[k]),
      .in_part   (part[k]),
      .in_nq     (nq[k]),
      .out_valid (valid[k+1]),
      .out_ready (ready[k+1]),
      .out_ctl   (ctl[k+1]),
      .out_den   (den[k+1]),
      .out_part  (part[k+1]),
      .out_nq    (nq[k+1])
    );
  end

  // After the last step, nq holds the full quotient and part the remainder.
  surd_fix #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_fix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (valid[DATA_WIDTH]),
    .in_ready (ready[DATA_WIDTH]),
    .in_ctl   (ctl[DATA_WIDTH]),
    .in_part  (part[DATA_WIDTH]),
    .in_nq    (nq[DATA_WIDTH]),
    .rsp      (rsp)
  );

  // The input can only back up when every stage is full and the output waits.
  `SURD_ASSERT_IMP(a_stall_needs_full_out, clk, rst, !req.ready, rsp.valid && !rsp.ready, "input stalled without a blocked output")
  `SURD_ASSERT_IMP(a_stall_needs_full_last, clk, rst, !req.ready, valid[DATA_WIDTH] && valid[0], "input stalled with room in the pipeline")

endmodule

// ===== sim/tb_signed_unsigned_restoring_divider.sv =====
`timescale 1ns / 100ps

module tb_signed_unsigned_restoring_divider;
  import surd_pkg::*;

  // The core runs DATA_WIDTH steps plus an input and an output stage.
  localparam int DIV_LATENCY = DATA_WIDTH_DEF + 2;

  // The watchdog trips after this many cycles with no word moving on either
  // side. In the slowest correct run a word waits out the pipeline latency,
  // plus a random receiver stall at 63 percent, plus a random sender gap.
  // Stall runs anywhere near this limit are vanishingly rare, so the limit
  // is several times the worst case that can really occur.
  localparam int STALL_LIMIT = 5000;

  // One accepted word together with the result that it must produce.
  typedef struct {
    cmd_t             op;
    logic [FIELD_W-1:0] num;
    logic [FIELD_W-1:0] den;
    logic [FIELD_W-1:0] want;
  } div_case_t;

  logic clk;
  logic rst;

  surd_cmd_if req_if ();
  surd_res_if rsp_if ();

  signed_unsigned_restoring_divider u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .rsp (rsp_if.source)
  );

  // Results still owed by the divider, oldest first.
  div_case_t awaited_answers[$];

  int error_count;
  int stall_cycles;

  // Idle percentages of the sender and of the receiver in the current phase.
  int src_idle_pct;
  int sink_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Every input of the block is known from time zero on.
  initial begin
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.command  = CMD_QUO_U;
    req_if.dividend = '0;
    req_if.divisor  = '0;
    rsp_if.ready    = 1'b0;
  end

  // Quotient or remainder that the command selects. Signed commands divide
  // the magnitudes; the quotient takes the sign of the product of the
  // operand signs and the remainder takes the sign of the dividend. A zero
  // divisor yields an all-ones magnitude quotient and the dividend as the
  // remainder; after the sign fix the signed quotient is 1 for a negative dividend.
  function automatic logic [FIELD_W-1:0] divide_word(cmd_t op, logic [FIELD_W-1:0] num,
                                                     logic [FIELD_W-1:0] den);
    logic               num_neg;
    logic               den_neg;
    logic [FIELD_W-1:0] mag_num;
    logic [FIELD_W-1:0] mag_den;
    logic [FIELD_W-1:0] quo;
    logic [FIELD_W-1:0] rem;
    num_neg = (op == CMD_QUO_S || op == CMD_REM_S) && num[FIELD_W-1];
    den_neg = (op == CMD_QUO_S || op == CMD_REM_S) && den[FIELD_W-1];
    mag_num = num_neg ? (~num + 1'b1) : num;
    mag_den = den_neg ? (~den + 1'b1) : den;
    if (mag_den == '0) begin
      quo = '1;
      rem = mag_num;
    end else begin
      quo = mag_num / mag_den;
      rem = mag_num % mag_den;
    end
    case (op)
      CMD_QUO_U: return quo;
      CMD_REM_U: return rem;
      CMD_QUO_S: return (num_neg != den_neg) ? (~quo + 1'b1) : quo;
      default:   return num_neg ? (~rem + 1'b1) : rem;
    endcase
  endfunction

  // Receiver side: ready changes at the falling edge, stalling at random
  // according to the current phase.
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Every result word is compared against the oldest owed result. A word
  // that arrives with nothing owed is an error in its own right.
  always @(posedge clk) begin : check_results
    div_case_t head;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h",
                 $time, rsp_if.result);
        error_count++;
      end else begin
        head = awaited_answers.pop_front();
        if (rsp_if.result !== head.want) begin
          $display("%0t: mismatch %s %h / %h: expected %h actual %h",
                   $time, head.op.name(), head.num, head.den, head.want, rsp_if.result);
          error_count++;
        end
      end
    end
  end

  // The watchdog only counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired with %0d results owed", $time,
                 awaited_answers.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offers one word to the divider. The task is entered and left at a
  // falling edge; valid stays high after acceptance so that a following word
  // goes out back to back unless the next call decides to idle first.
  task automatic send_word(cmd_t op, logic [FIELD_W-1:0] num, logic [FIELD_W-1:0] den);
    div_case_t entry;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.command  <= op;
    req_if.dividend <= num;
    req_if.divisor  <= den;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    entry.op   = op;
    entry.num  = num;
    entry.den  = den;
    entry.want = divide_word(op, num, den);
    awaited_answers.push_back(entry);
    @(negedge clk);
  endtask

  task automatic set_idle(int src_pct, int sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  // Each command with plain operands, the extremes of both fields, and
  // divisors with the top bit set.
  task automatic test_basic_ops();
    send_word(CMD_QUO_U, 32'd100, 32'd7);
    send_word(CMD_REM_U, 32'd100, 32'd7);
    send_word(CMD_QUO_U, 32'hFFFF_FFFF, 32'd1);
    send_word(CMD_QUO_U, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(CMD_QUO_U, 32'd0, 32'd5);
    send_word(CMD_QUO_U, 32'hFFFF_FFFF, 32'h8000_0000);
    send_word(CMD_REM_U, 32'hFFFF_FFFF, 32'h8000_0000);
    send_word(CMD_REM_U, 32'h8000_0000, 32'd3);
    // Signed forms with a negative dividend, a negative divisor or both.
    send_word(CMD_QUO_S, -32'sd7, 32'sd2);
    send_word(CMD_QUO_S, 32'sd7, -32'sd2);
    send_word(CMD_QUO_S, -32'sd7, -32'sd2);
    send_word(CMD_REM_S, -32'sd7, 32'sd2);
    send_word(CMD_REM_S, 32'sd7, -32'sd2);
    send_word(CMD_QUO_S, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // A zero divisor under every command, with positive, negative and zero
  // dividends. A negative dividend gives a signed quotient of one.
  task automatic test_zero_divisor();
    send_word(CMD_QUO_U, 32'h1234_5678, 32'd0);
    send_word(CMD_REM_U, 32'hDEAD_BEEF, 32'd0);
    send_word(CMD_QUO_S, 32'h1234_5678, 32'd0);
    send_word(CMD_QUO_S, 32'hDEAD_BEEF, 32'd0);
    send_word(CMD_REM_S, 32'hDEAD_BEEF, 32'd0);
    send_word(CMD_QUO_S, 32'd0, 32'd0);
  endtask

  // The most negative dividend over minus one wraps back to itself with a
  // zero remainder. It is also divided by itself.
  task automatic test_signed_overflow();
    send_word(CMD_QUO_S, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(CMD_REM_S, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(CMD_QUO_S, 32'h8000_0000, 32'h8000_0000);
    send_word(CMD_REM_S, 32'h8000_0000, 32'h8000_0000);
  endtask

  // Random words. Plain random operands mostly give tiny quotients, so part
  // of the mix uses small divisors, close operand pairs, zero divisors and
  // boundary values to exercise long quotients and the sign corrections.
  task automatic test_random_words(int count);
    cmd_t               op;
    logic [FIELD_W-1:0] num;
    logic [FIELD_W-1:0] den;
    logic [FIELD_W-1:0] edges[7];
    edges = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
              32'hFFFF_FFFF, 32'hFFFF_FFFE};
    for (int i = 0; i < count; i++) begin
      op  = cmd_t'($urandom_range(0, 3));
      num = $urandom();
      den = $urandom();
      case ($urandom_range(0, 9))
        4: begin
          den = $urandom_range(1, 255);
          if ($urandom_range(0, 1) == 1) den = ~den + 1'b1;
        end
        5: den = '0;
        6: begin
          if ($urandom_range(0, 1) == 1) den = num >> $urandom_range(0, 31);
          else den = num + $urandom_range(0, 2) - 1;
        end
        7: begin
          num = edges[$urandom_range(0, 6)];
          den = edges[$urandom_range(0, 6)];
        end
        8: begin
          num = {{16{num[31]}}, num[15:0]};
          den = {{24{den[31]}}, den[7:0]};
        end
        9: den[31] = 1'b1;
        default: ;
      endcase
      send_word(op, num, den);
    end
  endtask

  initial begin
    error_count  = 0;
    stall_cycles = 0;
    set_idle(20, 63);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_ops();
    test_zero_divisor();
    test_signed_overflow();

    // Random traffic in three idle patterns: slow receiver, slow sender,
    // then full rate on both sides.
    test_random_words(440);
    set_idle(63, 20);
    test_random_words(440);
    set_idle(0, 0);
    test_random_words(440);
    req_if.valid <= 1'b0;

    // Drain the pipeline, then linger long enough to catch stray words.
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (DIV_LATENCY + 4) @(posedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/surd_pkg.sv
rtl/surd_cmd_if.sv
rtl/surd_res_if.sv
rtl/surd_prep.sv
rtl/surd_step.sv
rtl/surd_fix.sv
rtl/signed_unsigned_restoring_divider.sv
sim/tb_signed_unsigned_restoring_divider.sv
